// ----- sv/rkw_pkg.sv -----
`timescale 1ns / 1ps

package rkw_pkg;

   // Field widths fixed by the interface
   localparam int OFFSET_W   = 7;
   localparam int WEIGHT_W   = 17;
   localparam int BW_W       = 6;
   localparam int B_W        = 7;   // bandwidth + 1
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   // Squared distance: full range, and the part that can lie inside any radius
   localparam int D2_W      = 14;
   localparam int D2_IN_W   = 12;
   localparam int INT_PAIRS = D2_IN_W / 2;

   // Divisor is at most B^4 = 2^24
   localparam int DEN_W = 25;
   localparam int B2_W  = 13;
   localparam int B3_W  = 19;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BANDWIDTH   = 1'd1;

   typedef enum logic [1:0] {
      KM_UNIFORM = 2'd0,
      KM_EPAN    = 2'd1,
      KM_QUARTIC = 2'd2,
      KM_TRICUBE = 2'd3
   } kmode_type;

endpackage

// ----- sv/rkw_sqrt.sv -----
`timescale 1ns / 1ps

// Fixed-point square root, one result bit per stage: floor(sqrt(v) * 2^FRAC_BITS)
module rkw_sqrt #(
   parameter int FRAC_BITS = 16,
   parameter int SB_W      = 1
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  logic                                     in_valid,
   input  logic [rkw_pkg::D2_IN_W-1:0]              in_v,
   input  logic [SB_W-1:0]                          in_sb,
   output logic                                     out_valid,
   output logic [rkw_pkg::D2_IN_W-1:0]              out_v,
   output logic [rkw_pkg::INT_PAIRS+FRAC_BITS-1:0]  out_root,
   output logic [SB_W-1:0]                          out_sb
);
   import rkw_pkg::*;

   localparam int P   = INT_PAIRS + FRAC_BITS;
   localparam int RW  = P;
   localparam int RMW = RW + 2;

   logic                vld_ff  [P];
   logic [D2_IN_W-1:0]  v_ff    [P];
   logic [RW-1:0]       root_ff [P];
   logic [RMW-1:0]      rem_ff  [P];
   logic [SB_W-1:0]     sb_ff   [P];

   for (genvar i = 0; i < P; i++) begin : g_st
      logic                vld_src;
      logic [D2_IN_W-1:0]  v_src;
      logic [RW-1:0]       root_src;
      logic [RMW-1:0]      rem_src;
      logic [SB_W-1:0]     sb_src;
      logic [1:0]          pair;
      logic [RW-1:0]       rs;
      logic [RMW+1:0]      rem_sh;
      logic [RMW+1:0]      trial;
      logic                take;
      logic [RW-1:0]       root_in;
      logic [RMW-1:0]      rem_in;

      if (i == 0) begin : g_first
         assign vld_src  = in_valid;
         assign v_src    = in_v;
         assign root_src = '0;
         assign rem_src  = '0;
         assign sb_src   = in_sb;
      end else begin : g_next
         assign vld_src  = vld_ff[i-1];
         assign v_src    = v_ff[i-1];
         assign root_src = root_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign sb_src   = sb_ff[i-1];
      end

      // Integer digit pairs first, then zero pairs for the fraction bits
      if (i < INT_PAIRS) begin : g_int
         assign pair = v_src[2*(INT_PAIRS-1-i) +: 2];
      end else begin : g_frac
         assign pair = 2'b00;
      end

      // Try 4*root+1 against the shifted remainder
      always_comb begin
         rs      = {root_src[RW-2:0], 1'b0};
         rem_sh  = {rem_src, pair};
         trial   = (RMW+2)'({rs, 1'b1});
         take    = (rem_sh >= trial);
         root_in = take ? (rs | RW'(1)) : rs;
         rem_in  = take ? RMW'(rem_sh - trial) : RMW'(rem_sh);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[i]    <= v_src;
            root_ff[i] <= root_in;
            rem_ff[i]  <= rem_in;
            sb_ff[i]   <= sb_src;
         end
      end
   end

   assign out_valid = vld_ff[P-1];
   assign out_v     = v_ff[P-1];
   assign out_root  = root_ff[P-1];
   assign out_sb    = sb_ff[P-1];

endmodule

// ----- sv/rkw_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage, most significant bit first.
// The quotient is known to fit FRAC_BITS+1 bits. The divisor is not carried along:
// the user must change it only while the pipeline is empty; the block does not enforce this.
module rkw_div #(
   parameter int FRAC_BITS = 16,
   parameter int SB_W      = 1
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  logic                                     in_valid,
   input  logic [rkw_pkg::DEN_W+FRAC_BITS:0]        in_num,
   input  logic [rkw_pkg::DEN_W-1:0]                den,
   input  logic [SB_W-1:0]                          in_sb,
   output logic                                     out_valid,
   output logic [FRAC_BITS:0]                       out_q,
   output logic [SB_W-1:0]                          out_sb
);
   import rkw_pkg::*;

   localparam int QW = FRAC_BITS + 1;
   localparam int CW = DEN_W + QW;

   logic             vld_ff [QW];
   logic [CW-1:0]    rem_ff [QW];
   logic [QW-1:0]    q_ff   [QW];
   logic [SB_W-1:0]  sb_ff  [QW];

   for (genvar i = 0; i < QW; i++) begin : g_st
      localparam int BIT = QW - 1 - i;

      logic             vld_src;
      logic [CW-1:0]    rem_src;
      logic [QW-1:0]    q_src;
      logic [SB_W-1:0]  sb_src;
      logic [CW-1:0]    dsh;
      logic             take;
      logic [CW-1:0]    rem_in;
      logic [QW-1:0]    q_in;

      if (i == 0) begin : g_first
         assign vld_src = in_valid;
         assign rem_src = in_num;
         assign q_src   = '0;
         assign sb_src  = in_sb;
      end else begin : g_next
         assign vld_src = vld_ff[i-1];
         assign rem_src = rem_ff[i-1];
         assign q_src   = q_ff[i-1];
         assign sb_src  = sb_ff[i-1];
      end

      // Compare and subtract the divisor at this bit weight
      always_comb begin
         dsh       = CW'(den) << BIT;
         take      = (rem_src >= dsh);
         rem_in    = take ? (rem_src - dsh) : rem_src;
         q_in      = q_src;
         q_in[BIT] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            q_ff[i]   <= q_in;
            sb_ff[i]  <= sb_src;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_q     = q_ff[QW-1];
   assign out_sb    = sb_ff[QW-1];

endmodule

// ----- sv/radial_kernel_weight_generator.sv -----
`timescale 1ns / 1ps

// Radial kernel weight generator.
// Each request beat carries one cell offset (row, column) from the window
// centre; each response beat carries that cell's kernel weight (unsigned,
// FRAC_BITS fraction bits, masked to 17 bits) and an inside-radius flag.
// Every request yields exactly one response, in order.
// Kernel mode and bandwidth are set through the csr write channel, which is
// always ready; write them only while no beat is in flight.
// Throughput: one beat per cycle while the response side does not stall.
// Depth: 2*FRAC_BITS+18 register stages, set by the bit-per-stage square root
// (FRAC_BITS+6 stages) and the bit-per-stage divider (FRAC_BITS+1 stages).
// When the response side stalls with a beat waiting, the whole pipeline
// holds and req_stall is raised; nothing is lost or repeated.
// Synchronous reset empties the pipeline and sets kernel mode to
// epanechnikov and bandwidth to 1.
module radial_kernel_weight_generator #(
   parameter int MAX_BANDWIDTH = 63,
   parameter int FRAC_BITS     = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [rkw_pkg::OFFSET_W-1:0]   req_row_offset,
   input  logic signed [rkw_pkg::OFFSET_W-1:0]   req_col_offset,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [rkw_pkg::WEIGHT_W-1:0]          rsp_weight,
   output logic                                  rsp_inside_res,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rkw_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rkw_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import rkw_pkg::*;

   localparam int QW = FRAC_BITS + 1;
   localparam int RW = INT_PAIRS + FRAC_BITS;
   localparam int NW = DEN_W + QW;
   localparam int TW = D2_IN_W + RW;
   localparam logic [QW-1:0] ONE  = QW'(1) << FRAC_BITS;
   localparam logic [QW-1:0] HALF = ONE >> 1;

   // ---------------- configuration ----------------
   kmode_type         kmode_ff;
   logic [BW_W-1:0]   bandwidth_ff;
   logic [BW_W-1:0]   bw_eff;
   logic [B_W-1:0]    b_full;
   logic [B2_W-1:0]   bwsq_ff;
   logic [B2_W-1:0]   b2_ff;
   logic [B_W-1:0]    b_ff;
   logic [B3_W-1:0]   b3_ff;
   logic [DEN_W-1:0]  b4_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kmode_ff     <= KM_EPAN;
         bandwidth_ff <= BW_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_KERNEL_MODE: kmode_ff     <= kmode_type'(csr_wdata[1:0]);
            REG_BANDWIDTH:   bandwidth_ff <= csr_wdata;
            default:         ;
         endcase
      end
   end

   // Derived constants, registered from the effective bandwidth after a write
   assign bw_eff = (8'(bandwidth_ff) > 8'(MAX_BANDWIDTH)) ? BW_W'(MAX_BANDWIDTH)
                                                           : bandwidth_ff;
   assign b_full = B_W'(bw_eff) + B_W'(1);

   always_ff @(posedge clock) begin
      bwsq_ff <= B2_W'(bw_eff) * B2_W'(bw_eff);
      b_ff    <= b_full;
      b2_ff   <= B2_W'(b_full) * B2_W'(b_full);
      b3_ff   <= B3_W'(b2_ff) * B3_W'(b_ff);
      b4_ff   <= DEN_W'(b2_ff) * DEN_W'(b2_ff);
   end

   // ---------------- pipeline control ----------------
   logic rsp_valid_ff;
   logic en;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // S0: input beat
   logic                        v0_ff;
   logic signed [OFFSET_W-1:0]  row_ff, col_ff;

   // S1: squares
   logic                        v1_ff;
   logic signed [2*OFFSET_W-1:0] rp, cp;
   logic [B2_W-1:0]             rsq_ff, csq_ff;

   // S2: squared distance and radius test
   logic                        v2_ff;
   logic [D2_W-1:0]             d2_in, d2_ff;
   logic                        inside2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   assign rp    = row_ff * row_ff;
   assign cp    = col_ff * col_ff;
   assign d2_in = D2_W'(rsq_ff) + D2_W'(csq_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         row_ff     <= req_row_offset;
         col_ff     <= req_col_offset;
         rsq_ff     <= rp[B2_W-1:0];
         csq_ff     <= cp[B2_W-1:0];
         d2_ff      <= d2_in;
         inside2_ff <= (d2_in <= D2_W'(bwsq_ff));
      end
   end

   // ---------------- square root ----------------
   logic                 sq_valid;
   logic [D2_IN_W-1:0]   sq_d2;
   logic [RW-1:0]        sq_root;
   logic                 sq_inside;

   rkw_sqrt #(
      .FRAC_BITS (FRAC_BITS),
      .SB_W      (1)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v2_ff),
      .in_v      (d2_ff[D2_IN_W-1:0]),
      .in_sb     (inside2_ff),
      .out_valid (sq_valid),
      .out_v     (sq_d2),
      .out_root  (sq_root),
      .out_sb    (sq_inside)
   );

   // ---------------- numerator build ----------------
   // N1: B^2-d2 and d2*sqrt(d2)
   logic                 n1_v_ff, n1_inside_ff;
   logic [B2_W-1:0]      diff_ff;
   logic [TW-1:0]        tri_ff;
   // N2: (B^2-d2)^2
   logic                 n2_v_ff, n2_inside_ff;
   logic [B2_W-1:0]      diff2_ff;
   logic [TW-1:0]        tri2_ff;
   logic [2*B2_W-1:0]    dsq_ff;
   // N3: rounded numerator
   logic                 n3_v_ff, n3_inside_ff;
   logic [NW-1:0]        num_in, num_ff;
   logic [DEN_W-1:0]     den;

   always_comb begin
      case (kmode_ff)
         KM_QUARTIC: den = b4_ff;
         KM_TRICUBE: den = DEN_W'(b3_ff);
         default:    den = DEN_W'(b2_ff);
      endcase
   end

   always_comb begin
      case (kmode_ff)
         KM_EPAN:    num_in = (NW'(diff2_ff) << FRAC_BITS) + NW'(den >> 1);
         KM_QUARTIC: num_in = (NW'(dsq_ff) << FRAC_BITS) + NW'(den >> 1);
         KM_TRICUBE: num_in = NW'(tri2_ff) + NW'(den >> 1);
         default:    num_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_v_ff <= 1'b0;
         n2_v_ff <= 1'b0;
         n3_v_ff <= 1'b0;
      end else if (en) begin
         n1_v_ff <= sq_valid;
         n2_v_ff <= n1_v_ff;
         n3_v_ff <= n2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_inside_ff <= sq_inside;
         diff_ff      <= b2_ff - B2_W'(sq_d2);
         tri_ff       <= TW'(sq_d2) * TW'(sq_root);
         n2_inside_ff <= n1_inside_ff;
         diff2_ff     <= diff_ff;
         tri2_ff      <= tri_ff;
         dsq_ff       <= diff_ff * diff_ff;
         n3_inside_ff <= n2_inside_ff;
         num_ff       <= num_in;
      end
   end

   // ---------------- divider ----------------
   logic           dv_valid;
   logic [QW-1:0]  dv_q;
   logic           dv_inside;

   rkw_div #(
      .FRAC_BITS (FRAC_BITS),
      .SB_W      (1)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (n3_v_ff),
      .in_num    (num_ff),
      .den       (den),
      .in_sb     (n3_inside_ff),
      .out_valid (dv_valid),
      .out_q     (dv_q),
      .out_sb    (dv_inside)
   );

   // ---------------- tricube cube ----------------
   logic             t1_v_ff, t2_v_ff, t3_v_ff, t4_v_ff;
   logic             t1_in_ff, t2_in_ff, t3_in_ff, t4_in_ff;
   logic [QW-1:0]    q1_ff, q2_ff, q3_ff, q4_ff;
   logic [QW-1:0]    t_ff, tb_ff, tc_ff;
   logic [2*QW-1:0]  tt_ff, tt_rnd;
   logic [QW-1:0]    t2_ff;
   logic [2*QW-1:0]  p_ff, p_rnd;

   assign tt_rnd = tt_ff + (2*QW)'(HALF);
   assign p_rnd  = p_ff + (2*QW)'(HALF);

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_v_ff <= 1'b0;
         t2_v_ff <= 1'b0;
         t3_v_ff <= 1'b0;
         t4_v_ff <= 1'b0;
      end else if (en) begin
         t1_v_ff <= dv_valid;
         t2_v_ff <= t1_v_ff;
         t3_v_ff <= t2_v_ff;
         t4_v_ff <= t3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // T1: 1 - x, floored at zero
         t1_in_ff <= dv_inside;
         q1_ff    <= dv_q;
         t_ff     <= (dv_q >= ONE) ? '0 : (ONE - dv_q);
         // T2: t^2
         t2_in_ff <= t1_in_ff;
         q2_ff    <= q1_ff;
         tb_ff    <= t_ff;
         tt_ff    <= t_ff * t_ff;
         // T3: round back to FRAC_BITS
         t3_in_ff <= t2_in_ff;
         q3_ff    <= q2_ff;
         tc_ff    <= tb_ff;
         t2_ff    <= tt_rnd[FRAC_BITS +: QW];
         // T4: t^2 * t
         t4_in_ff <= t3_in_ff;
         q4_ff    <= q3_ff;
         p_ff     <= t2_ff * tc_ff;
      end
   end

   // ---------------- output register ----------------
   logic [QW-1:0]           w_sel;
   logic [QW+WEIGHT_W-1:0]  w_ext;
   logic [WEIGHT_W-1:0]     weight_in, weight_ff;
   logic                    inside_ff;

   always_comb begin
      case (kmode_ff)
         KM_UNIFORM: w_sel = ONE;
         KM_TRICUBE: w_sel = p_rnd[FRAC_BITS +: QW];
         default:    w_sel = q4_ff;
      endcase
   end

   assign w_ext     = (QW+WEIGHT_W)'(t4_in_ff ? w_sel : '0);
   assign weight_in = w_ext[WEIGHT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= t4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         weight_ff <= weight_in;
         inside_ff <= t4_in_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_weight     = weight_ff;
   assign rsp_inside_res = inside_ff;

   // ---------------- assertions ----------------
   // Cells outside the radius always carry zero weight
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_inside_res) |-> (rsp_weight == '0))
      else $error("non-zero weight outside radius");

   // Rounded quotients never exceed 1.0 for cells inside the radius
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      (dv_valid && dv_inside && kmode_ff != KM_UNIFORM) |-> (dv_q <= ONE))
      else $error("divider quotient above one");

   // The square root of an inside cell stays below 64
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      (sq_valid && sq_inside) |-> ({1'b0, sq_root} < ((RW+1)'(64) << FRAC_BITS)))
      else $error("square root out of range");

   // A stall on the response side freezes the front of the pipeline
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(v0_ff) && $stable(row_ff)))
      else $error("pipeline moved under stall");

endmodule
